FILE: rtl/core/vpa_pkg.sv
// Shared types, codes and defaults for the variable partition allocator.
`default_nettype none
package vpa_pkg;

	localparam int LEN_W = 10;
	localparam int FIELD_W = 10;
	localparam int DEF_MAX_SEGMENTS = 16;
	localparam int DEF_ADDR_BITS = 10;
	localparam logic [LEN_W-1:0] SIZE_RESET = 10'd320;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] REG_FIT_POLICY = 2'd0;
	localparam logic [1:0] REG_TOTAL_SIZE = 2'd1;

	typedef struct packed {
		logic command;
		logic [FIELD_W-1:0] request_length;
		logic [FIELD_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [FIELD_W-1:0] block_address;
		logic [FIELD_W-1:0] block_length;
	} rsp_t;

	typedef struct packed {
		logic init;
		logic load;
		logic scan;
		logic plan;
		logic shift;
		logic fin_a;
		logic fin_b;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic ok;
		logic second;
		logic out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/vpa_datapath.sv
// Segment table memory, scan, shift and merge datapath with result register.
`default_nettype none
module vpa_datapath #(
	parameter int MAX_SEGMENTS = vpa_pkg::DEF_MAX_SEGMENTS,
	parameter int ADDR_BITS = vpa_pkg::DEF_ADDR_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire vpa_pkg::ctl_cmd_t cmd,
	output vpa_pkg::ctl_sts_t sts,
	input wire vpa_pkg::req_t req,
	input wire logic cfg_valid,
	input wire logic [1:0] cfg_index,
	input wire logic [vpa_pkg::FIELD_W-1:0] cfg_data,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output vpa_pkg::rsp_t rsp
);
	localparam int LW = vpa_pkg::LEN_W;
	localparam int IDX_W = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int ENT_W = ADDR_BITS + LW + 1;

	logic [ENT_W-1:0] mem_q [MAX_SEGMENTS];
	logic [ENT_W-1:0] rdata_q;

	logic [1:0] fit_q;
	logic [LW-1:0] size_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] k_q;
	logic rv_s1;
	logic [IDX_W-1:0] ridx_s1;
	logic found_q;
	logic has_prev_q;
	logic has_next_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] src_q;
	logic up_q;
	logic [1:0] r_q;
	logic wv_s1;
	logic [IDX_W-1:0] dst_s1;
	logic rsp_valid_q;

	logic cmd_q;
	logic [LW-1:0] len_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [IDX_W-1:0] pick_idx_q;
	logic [ADDR_BITS-1:0] pick_start_q;
	logic [LW-1:0] pick_len_q;
	logic [ENT_W-1:0] last_q;
	logic [ENT_W-1:0] prev_q;
	logic [LW-1:0] next_len_q;
	logic next_used_q;
	logic [1:0] status_q;
	logic [IDX_W-1:0] fa_idx_q;
	logic [ENT_W-1:0] fa_q;
	logic [ENT_W-1:0] fb_q;
	logic [CNT_W-1:0] new_count_q;
	logic second_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	logic [LW-1:0] res_len_q;
	vpa_pkg::rsp_t rsp_q;

	logic cfg_size_wr;
	logic scan_iss;
	logic shift_iss;
	logic [ADDR_BITS-1:0] e_start;
	logic [LW-1:0] e_len;
	logic e_used;
	logic take;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [ENT_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_idx;
	logic out_free;

	// plan outcome
	logic [1:0] p_status;
	logic [CNT_W-1:0] p_n;
	logic [CNT_W-1:0] p_src;
	logic p_up;
	logic [1:0] p_r;
	logic [IDX_W-1:0] p_fa_idx;
	logic [ENT_W-1:0] p_fa;
	logic [ENT_W-1:0] p_fb;
	logic [CNT_W-1:0] p_count;
	logic p_second;
	logic [ADDR_BITS-1:0] p_addr;
	logic [LW-1:0] p_len;
	logic split;
	logic mp;
	logic mn;
	logic [ADDR_BITS-1:0] m_start;
	logic [LW-1:0] m_len;

	assign cfg_size_wr = cfg_valid && (cfg_index == vpa_pkg::REG_TOTAL_SIZE);
	assign scan_iss = cmd.scan && (k_q < count_q);
	assign shift_iss = cmd.shift && (n_q != '0);
	assign e_start = rdata_q[ENT_W-1 -: ADDR_BITS];
	assign e_len = rdata_q[LW:1];
	assign e_used = rdata_q[0];
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (cmd_q == vpa_pkg::CMD_ALLOC) begin
			take = !e_used && (e_len >= len_q) && (!found_q
				|| (fit_q == vpa_pkg::FIT_BEST && e_len < pick_len_q)
				|| (fit_q == vpa_pkg::FIT_WORST && e_len > pick_len_q));
		end else begin
			take = e_used && (e_start == addr_q) && !found_q;
		end
	end

	always_comb begin
		rd_idx = cmd.shift ? src_q[IDX_W-1:0] : k_q[IDX_W-1:0];
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		if (cfg_size_wr) begin
			wr_en = 1'b1;
			wr_data = {{ADDR_BITS{1'b0}}, cfg_data, 1'b0};
		end else if (cmd.init) begin
			wr_en = 1'b1;
			wr_data = {{ADDR_BITS{1'b0}}, size_q, 1'b0};
		end else if (wv_s1) begin
			wr_en = 1'b1;
			wr_idx = dst_s1;
			wr_data = rdata_q;
		end else if (cmd.fin_a) begin
			wr_en = 1'b1;
			wr_idx = fa_idx_q;
			wr_data = fa_q;
		end else if (cmd.fin_b) begin
			wr_en = 1'b1;
			wr_idx = IDX_W'(fa_idx_q + 1'b1);
			wr_data = fb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		rdata_q <= mem_q[rd_idx];
	end

	always_comb begin
		split = pick_len_q > len_q;
		mp = has_prev_q && !prev_q[0];
		mn = has_next_q && !next_used_q;
		m_start = mp ? prev_q[ENT_W-1 -: ADDR_BITS] : pick_start_q;
		m_len = pick_len_q + (mp ? prev_q[LW:1] : '0) + (mn ? next_len_q : '0);
		p_status = vpa_pkg::ST_OK;
		p_n = '0;
		p_src = count_q - 1'b1;
		p_up = 1'b1;
		p_r = '0;
		p_fa_idx = pick_idx_q;
		p_fa = {pick_start_q, len_q, 1'b1};
		p_fb = {ADDR_BITS'(pick_start_q + ADDR_BITS'(len_q)), LW'(pick_len_q - len_q), 1'b0};
		p_count = count_q;
		p_second = 1'b0;
		p_addr = pick_start_q;
		p_len = len_q;
		if (cmd_q == vpa_pkg::CMD_ALLOC) begin
			if (len_q == '0 || !found_q) begin
				p_status = vpa_pkg::ST_NOFIT;
			end else if (split && count_q == CNT_W'(MAX_SEGMENTS)) begin
				p_status = vpa_pkg::ST_FULL;
			end else if (split) begin
				p_n = count_q - 1'b1 - CNT_W'(pick_idx_q);
				p_count = count_q + 1'b1;
				p_second = 1'b1;
			end
		end else begin
			if (!found_q) begin
				p_status = vpa_pkg::ST_BADFREE;
			end else begin
				p_up = 1'b0;
				p_r = {1'b0, mp} + {1'b0, mn};
				p_src = CNT_W'(pick_idx_q) + 1'b1 + CNT_W'(mn);
				if (mp || mn) begin
					p_n = count_q - 1'b1 - CNT_W'(pick_idx_q) - CNT_W'(mn);
				end
				p_count = count_q - CNT_W'(p_r);
				p_fa_idx = mp ? IDX_W'(pick_idx_q - 1'b1) : pick_idx_q;
				p_fa = {m_start, m_len, 1'b0};
				p_addr = m_start;
				p_len = m_len;
			end
		end
		if (p_status != vpa_pkg::ST_OK) begin
			p_addr = '0;
			p_len = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= vpa_pkg::FIT_FIRST;
			size_q <= vpa_pkg::SIZE_RESET;
			count_q <= CNT_W'(1);
			k_q <= '0;
			rv_s1 <= 1'b0;
			found_q <= 1'b0;
			has_prev_q <= 1'b0;
			has_next_q <= 1'b0;
			n_q <= '0;
			wv_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1 <= scan_iss;
			wv_s1 <= shift_iss;
			if (cfg_valid && cfg_index == vpa_pkg::REG_FIT_POLICY) begin
				fit_q <= cfg_data[1:0];
			end
			if (cfg_size_wr) begin
				size_q <= cfg_data;
				count_q <= CNT_W'(cfg_data != '0);
			end else if (cmd.init) begin
				count_q <= CNT_W'(size_q != '0);
			end else if (cmd.fin_a) begin
				count_q <= new_count_q;
			end
			if (cmd.load) begin
				k_q <= '0;
				found_q <= 1'b0;
				has_prev_q <= 1'b0;
				has_next_q <= 1'b0;
			end else if (cmd.scan) begin
				if (scan_iss) begin
					k_q <= k_q + 1'b1;
				end
				if (rv_s1) begin
					if (take) begin
						found_q <= 1'b1;
						has_prev_q <= ridx_s1 != '0;
					end
					if (cmd_q == vpa_pkg::CMD_FREE && found_q
						&& ridx_s1 == IDX_W'(pick_idx_q + 1'b1)) begin
						has_next_q <= 1'b1;
					end
				end
			end
			if (cmd.plan) begin
				n_q <= p_n;
			end else if (shift_iss) begin
				n_q <= n_q - 1'b1;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= k_q[IDX_W-1:0];
		if (cmd.load) begin
			cmd_q <= req.command;
			len_q <= LW'(ADDR_BITS'(req.request_length));
			addr_q <= ADDR_BITS'(req.free_address);
		end
		if (cmd.scan && rv_s1) begin
			last_q <= rdata_q;
			if (take) begin
				pick_idx_q <= ridx_s1;
				pick_start_q <= e_start;
				pick_len_q <= e_len;
				prev_q <= last_q;
			end
			if (found_q && ridx_s1 == IDX_W'(pick_idx_q + 1'b1)) begin
				next_len_q <= e_len;
				next_used_q <= e_used;
			end
		end
		if (cmd.plan) begin
			status_q <= p_status;
			src_q <= p_src;
			up_q <= p_up;
			r_q <= p_r;
			fa_idx_q <= p_fa_idx;
			fa_q <= p_fa;
			fb_q <= p_fb;
			new_count_q <= p_count;
			second_q <= p_second;
			res_addr_q <= p_addr;
			res_len_q <= p_len;
		end else if (shift_iss) begin
			src_q <= up_q ? CNT_W'(src_q - 1'b1) : CNT_W'(src_q + 1'b1);
		end
		// moves go one slot up for a split, r slots down for a merge
		dst_s1 <= up_q ? IDX_W'(src_q + 1'b1) : IDX_W'(src_q - CNT_W'(r_q));
		if (cmd.emit) begin
			rsp_q.status <= status_q;
			rsp_q.block_address <= vpa_pkg::FIELD_W'(res_addr_q);
			rsp_q.block_length <= res_len_q;
		end
	end

	assign sts.scan_done = (k_q >= count_q) && !rv_s1;
	assign sts.shift_done = (n_q == '0) && !wv_s1;
	assign sts.ok = status_q == vpa_pkg::ST_OK;
	assign sts.second = second_q;
	assign sts.out_free = out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire

FILE: rtl/core/vpa_ctrl.sv
// Sequencer that steps one item through scan, plan, shift, update and result.
`default_nettype none
module vpa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire vpa_pkg::ctl_sts_t sts,
	output vpa_pkg::ctl_cmd_t cmd
);
	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_PLAN = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_FIN_A = 3'd5;
	localparam logic [2:0] S_FIN_B = 3'd6;
	localparam logic [2:0] S_OUT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_PLAN;
				end
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_d = sts.ok ? S_FIN_A : S_OUT;
				end
			end
			S_FIN_A: begin
				cmd.fin_a = 1'b1;
				state_d = sts.second ? S_FIN_B : S_OUT;
			end
			S_FIN_B: begin
				cmd.fin_b = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the result register can take the beat
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule
`default_nettype wire

FILE: rtl/core/variable_partition_allocator.sv
// Top level of the variable partition allocator: sequencer plus segment datapath.
// Requests are taken one at a time, only in the idle state, after the previous result is emitted.
// A result waits in an output register while the next request is already taken.
// Reset: asynchronous; the init state that follows reset loads the table with one free segment.
`default_nettype none
module variable_partition_allocator #(
	parameter int MAX_SEGMENTS = vpa_pkg::DEF_MAX_SEGMENTS,
	parameter int ADDR_BITS = vpa_pkg::DEF_ADDR_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire vpa_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output vpa_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [vpa_pkg::FIELD_W-1:0] cfg_data
);
	vpa_pkg::ctl_cmd_t cmd;
	vpa_pkg::ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	vpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts(sts),
		.cmd(cmd)
	);

	vpa_datapath #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

FILE: rtl/core/vpa_checker.sv
// Port-level checks for the allocator, bound to the top level.
`default_nettype none
module vpa_port_checks (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire vpa_pkg::rsp_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != vpa_pkg::ST_OK |->
		rsp.block_address == '0 && rsp.block_length == '0)
		else $error("error result carries a block");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == vpa_pkg::ST_OK |-> rsp.block_length != '0)
		else $error("ok result with empty block");

endmodule

bind variable_partition_allocator vpa_port_checks u_vpa_port_checks (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);
`default_nettype wire

FILE: tb/sv/vpa_checker.sv
// Checker for the partition allocator: tracks the segment table, predicts and compares results.
module vpa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire vpa_pkg::req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire vpa_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [vpa_pkg::FIELD_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import vpa_pkg::*;

	localparam int NSEG = DEF_MAX_SEGMENTS;

	logic [1:0] policy;
	logic [9:0] mem_size;
	logic [9:0] seg_start [NSEG];
	logic [9:0] seg_len [NSEG];
	logic seg_used [NSEG];
	int seg_count;
	rsp_t expected_rsp [$];

	assign pending = expected_rsp.size();

	function automatic void clear_table();
		for (int k = 0; k < NSEG; k++) begin
			seg_start[k] = '0;
			seg_len[k] = '0;
			seg_used[k] = 1'b0;
		end
		seg_count = (mem_size == 0) ? 0 : 1;
		seg_len[0] = mem_size;
	endfunction

	function automatic void drop_entry(int idx);
		for (int k = idx; k + 1 < seg_count; k++) begin
			seg_start[k] = seg_start[k+1];
			seg_len[k] = seg_len[k+1];
			seg_used[k] = seg_used[k+1];
		end
		seg_count--;
		seg_start[seg_count] = '0;
		seg_len[seg_count] = '0;
		seg_used[seg_count] = 1'b0;
	endfunction

	function automatic rsp_t allocate(logic [9:0] want);
		rsp_t r;
		int pick;
		bit found;
		r = '0;
		pick = 0;
		found = 0;
		if (want == 0) begin
			r.status = ST_NOFIT;
			return r;
		end
		for (int k = 0; k < seg_count; k++) begin
			if (seg_used[k] || seg_len[k] < want)
				continue;
			if (!found) begin
				pick = k;
				found = 1;
				if (policy != FIT_BEST && policy != FIT_WORST)
					break;
			end else if (policy == FIT_BEST && seg_len[k] < seg_len[pick]) begin
				pick = k;
			end else if (policy == FIT_WORST && seg_len[k] > seg_len[pick]) begin
				pick = k;
			end
		end
		if (!found) begin
			r.status = ST_NOFIT;
			return r;
		end
		if (seg_len[pick] > want) begin
			if (seg_count >= NSEG) begin
				r.status = ST_FULL;
				return r;
			end
			for (int k = seg_count; k > pick + 1; k--) begin
				seg_start[k] = seg_start[k-1];
				seg_len[k] = seg_len[k-1];
				seg_used[k] = seg_used[k-1];
			end
			seg_start[pick+1] = seg_start[pick] + want;
			seg_len[pick+1] = seg_len[pick] - want;
			seg_used[pick+1] = 1'b0;
			seg_len[pick] = want;
			seg_count++;
		end
		seg_used[pick] = 1'b1;
		r.status = ST_OK;
		r.block_address = seg_start[pick];
		r.block_length = want;
		return r;
	endfunction

	function automatic rsp_t release_block(logic [9:0] where);
		rsp_t r;
		int idx;
		r = '0;
		idx = -1;
		for (int k = 0; k < seg_count; k++) begin
			if (seg_used[k] && seg_start[k] == where) begin
				idx = k;
				break;
			end
		end
		if (idx < 0) begin
			r.status = ST_BADFREE;
			return r;
		end
		seg_used[idx] = 1'b0;
		if (idx + 1 < seg_count && !seg_used[idx+1]) begin
			seg_len[idx] = seg_len[idx] + seg_len[idx+1];
			drop_entry(idx + 1);
		end
		if (idx > 0 && !seg_used[idx-1]) begin
			seg_len[idx-1] = seg_len[idx-1] + seg_len[idx];
			drop_entry(idx);
			idx--;
		end
		r.status = ST_OK;
		r.block_address = seg_start[idx];
		r.block_length = seg_len[idx];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			policy = FIT_FIRST;
			mem_size = SIZE_RESET;
			clear_table();
			expected_rsp.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FIT_POLICY) begin
					policy = cfg_data[1:0];
				end else if (cfg_index == REG_TOTAL_SIZE) begin
					mem_size = cfg_data;
					clear_table();
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(req.command == CMD_ALLOC ?
					allocate(req.request_length) : release_block(req.free_address));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, rsp);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						fail_count++;
					end
					if (rsp.block_address !== want.block_address) begin
						$display("%0t: block_address expected %0d actual %0d",
							$time, want.block_address, rsp.block_address);
						fail_count++;
					end
					if (rsp.block_length !== want.block_length) begin
						$display("%0t: block_length expected %0d actual %0d",
							$time, want.block_length, rsp.block_length);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

FILE: tb/sv/testbench.sv
// Top of the allocator testbench: clock, reset, stimulus phases and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vpa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [FIELD_W-1:0] cfg_data = '0;
	int fail_count;
	int pending;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 0;
	longint cycle_count = 0;
	logic [9:0] live_addr [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	variable_partition_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	vpa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver side; a hold-off keeps stall high regardless of the random rate.
	always @(posedge clk) begin
		if (hold_off)
			rsp_stall <= 1'b1;
		else
			rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Track the block addresses of all OK results, frees included, as targets for later frees.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.block_length != 0)
			live_addr.push_back(rsp.block_address);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Valid stays high from one beat to the next unless the sender idles.
	task automatic send(logic cmd, logic [9:0] len, logic [9:0] addr);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req.command <= cmd;
		req.request_length <= len;
		req.free_address <= addr;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_item(int size);
		int pick;
		logic [9:0] a;
		if (live_addr.size() > 0 && $urandom_range(99) < 45) begin
			pick = $urandom_range(live_addr.size() - 1);
			a = live_addr[pick];
			live_addr.delete(pick);
			send(CMD_FREE, 10'($urandom), a);
		end else if ($urandom_range(99) < 8) begin
			send(1'($urandom_range(1)), 10'($urandom), 10'($urandom));
		end else begin
			send(CMD_ALLOC, 10'($urandom_range(1, size / 6 + 1)), 10'($urandom));
		end
	endtask

	task automatic new_setting(logic [1:0] pol, logic [9:0] size);
		drain();
		write_reg(REG_FIT_POLICY, pol);
		write_reg(REG_TOTAL_SIZE, size);
		live_addr.delete();
	endtask

	initial begin
		logic [9:0] sizes [6];
		sizes = '{10'd320, 10'd1023, 10'd1, 10'd40, 10'd700, 10'd160};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: extremes, exact fit, zero length, bad free, merge both sides.
		send(CMD_ALLOC, 10'd0, 10'd0);
		send(CMD_ALLOC, 10'd1023, 10'd0);
		send(CMD_ALLOC, 10'd10, 10'h3FF);
		send(CMD_ALLOC, 10'd20, 10'd0);
		send(CMD_ALLOC, 10'd30, 10'd0);
		send(CMD_FREE, 10'd0, 10'd5);
		send(CMD_FREE, 10'h3FF, 10'd0);
		send(CMD_FREE, 10'd0, 10'd30);
		send(CMD_FREE, 10'd0, 10'd10);
		send(CMD_FREE, 10'd0, 10'd0);
		send(CMD_ALLOC, 10'd320, 10'd0);
		send(CMD_FREE, 10'd0, 10'd0);
		for (int k = 0; k < 17; k++)
			send(CMD_ALLOC, 10'd1, 10'd0);
		new_setting(2'd3, 10'd0);
		send(CMD_ALLOC, 10'd1, 10'd0);
		send(CMD_FREE, 10'd0, 10'd0);
		new_setting(FIT_BEST, 10'd1023);
		send(CMD_ALLOC, 10'd1023, 10'd0);
		send(CMD_FREE, 10'd0, 10'd0);

		for (int ph = 0; ph < 12; ph++) begin
			new_setting(2'(ph % 4), sizes[ph % 6]);
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 82; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 82; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			if (ph == 4) begin
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int n = 0; n < 70; n++)
				random_item(sizes[ph % 6]);
		end
		send_idle_pct = 0;
		stall_pct = 0;
		drain();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
